// ===== rtl/zone_alarm_controller_unit_assert.svh =====
// Assertion macros shared by the alarm controller RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ZONE_ALARM_CONTROLLER_UNIT_ASSERT_SVH
`define ZONE_ALARM_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define ZAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ZAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/zac_pkg.sv =====
// Shared types and constants for the zone alarm controller.
// Used by zac_front, zac_back and the top level; no dependencies.
package zac_pkg;

  localparam int ZONES  = 2;
  localparam int ZONE_W = (ZONES > 1) ? $clog2(ZONES) : 1;

  // queues between front/back and on the result side
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 4;

  // input operation codes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;

  // frame identifiers
  localparam int ID_BUTTON      = 'h050;
  localparam int ID_FLAGS_BASE  = 'h100;
  localparam int ID_HB_BASE     = 'h1A0;
  localparam int ID_ZONE_STRIDE = 'h10;
  localparam logic [7:0] BTN_PRESS = 8'h01;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_TGL  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TGL  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_BEEP   = CFG_IDX_W'(3);

  localparam logic [15:0] HB_TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] ALERT_TGL_RST  = 16'd200;
  localparam logic [15:0] FAULT_TGL_RST  = 16'd1000;
  localparam logic [15:0] ARM_BEEP_RST   = 16'd100;

  localparam logic [2:0] BEEP_STEPS = 3'd6;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_BUTTON,
    CMD_FLAGS,
    CMD_HB,
    CMD_UNKNOWN,
    CMD_TICK,
    CMD_ACK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ZONE_W-1:0] zone;
    logic              press;
    logic              door;
    logic              motion;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             alarm;
    logic             buzzer;
    logic [ZONES-1:0] alive;
    logic [ZONES-1:0] triggered;
    logic [ZONES-1:0] faulted;
    logic             unknown;
  } res_t;

endpackage

// ===== rtl/zac_front.sv =====
// Front end: accepts input items, decodes frame ids into commands and
// buffers them in a short command queue. Depends on zac_pkg.
module zac_front import zac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_sid_high,
  input  logic [7:0] in_sid_low,
  input  logic [7:0] in_length_code,
  input  logic [7:0] in_first_byte,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  logic [10:0] frame_id;
  logic        has_payload;
  cmd_t        dec;
  logic        flags_hit;
  logic        hb_hit;

  cmd_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push_ok, pop_ok;

  assign frame_id    = {in_sid_high, in_sid_low[7:5]};
  assign has_payload = (in_length_code[3:0] != 4'd0);

  always_comb begin
    dec        = '0;
    dec.kind   = CMD_NOP;
    dec.press  = (in_first_byte == BTN_PRESS);
    dec.door   = in_first_byte[0];
    dec.motion = in_first_byte[1];
    flags_hit  = 1'b0;
    hb_hit     = 1'b0;
    case (in_operation)
      OP_FRAME: begin
        if (frame_id == 11'(ID_BUTTON) && has_payload) begin
          dec.kind = CMD_BUTTON;
        end else begin
          // flags ids win over heartbeat ids; lowest zone first
          for (int z = ZONES - 1; z >= 0; z--) begin
            if (frame_id == 11'(ID_FLAGS_BASE + z * ID_ZONE_STRIDE) && has_payload) begin
              flags_hit = 1'b1;
              dec.zone  = ZONE_W'(z);
            end
          end
          if (!flags_hit) begin
            for (int z = ZONES - 1; z >= 0; z--) begin
              if (frame_id == 11'(ID_HB_BASE + z * ID_ZONE_STRIDE)) begin
                hb_hit   = 1'b1;
                dec.zone = ZONE_W'(z);
              end
            end
          end
          if (flags_hit) dec.kind = CMD_FLAGS;
          else if (hb_hit) dec.kind = CMD_HB;
          else dec.kind = CMD_UNKNOWN;
        end
      end
      OP_TICK: dec.kind = CMD_TICK;
      OP_ACK:  dec.kind = CMD_ACK;
      default: dec.kind = CMD_NOP;
    endcase
  end

  assign in_full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign pop_ok    = cmd_take && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wp_r <= (wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop_ok) begin
        rp_r <= (rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push_ok && !pop_ok) cnt_r <= cnt_r + 1'b1;
      else if (!push_ok && pop_ok) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= dec;
  end

endmodule

// ===== rtl/zac_back.sv =====
// Back end: executes commands against the mode, zone and buzzer state,
// holds the configuration registers and the result queue. Depends on zac_pkg.
`include "zone_alarm_controller_unit_assert.svh"
module zac_back import zac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_take,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 out_pop,
  output logic                 out_empty,
  output res_t                 res
);

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_ALERT    = 2'd2,
    MODE_FAULT    = 2'd3
  } mode_t;

  logic [15:0] hb_timeout_r, alert_tgl_r, fault_tgl_r, arm_beep_r;

  mode_t            mode_r, mode_nxt;
  logic             alarm_r, alarm_nxt;
  logic [ZONES-1:0] door_r, door_nxt;
  logic [ZONES-1:0] motion_r, motion_nxt;
  logic [ZONES-1:0] alive_r, alive_nxt;
  logic [ZONES-1:0] seen_r, seen_nxt;
  logic [ZONES-1:0] fault_r, fault_nxt;
  // ms since each zone's last heartbeat (wraps like a 32-bit difference)
  logic [31:0]      elap_r [ZONES];
  logic [31:0]      elap_nxt [ZONES];
  logic [31:0]      now_r, now_nxt;
  mode_t            last_mode_r, last_mode_nxt;
  logic             beep_on_r, beep_on_nxt;
  logic [2:0]       beep_step_r, beep_step_nxt;
  logic [31:0]      beep_next_r, beep_next_nxt;
  logic [31:0]      alert_elap_r, alert_elap_nxt;
  logic [31:0]      fault_elap_r, fault_elap_nxt;
  logic             buzzer_r, buzzer_nxt;

  res_t               rq_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] rwp_r, rrp_r;
  logic [Q_CNT_W-1:0] rq_cnt_r;
  logic               exec, rpop;
  res_t               res_nxt;

  // scratch for the command update
  logic        recov;
  logic        timed_out;
  logic [1:0]  ev_set, ev_clr;
  logic [31:0] ae, fe;

  assign exec      = cmd_valid && ((rq_cnt_r != Q_CNT_W'(Q_DEPTH)) || out_pop);
  assign cmd_take  = exec;
  assign out_empty = (rq_cnt_r == '0);
  assign rpop      = out_pop && !out_empty;
  assign res       = rq_r[rrp_r];

  always_comb begin
    mode_nxt       = mode_r;
    alarm_nxt      = alarm_r;
    door_nxt       = door_r;
    motion_nxt     = motion_r;
    alive_nxt      = alive_r;
    seen_nxt       = seen_r;
    fault_nxt      = fault_r;
    elap_nxt       = elap_r;
    now_nxt        = now_r;
    last_mode_nxt  = last_mode_r;
    beep_on_nxt    = beep_on_r;
    beep_step_nxt  = beep_step_r;
    beep_next_nxt  = beep_next_r;
    alert_elap_nxt = alert_elap_r;
    fault_elap_nxt = fault_elap_r;
    buzzer_nxt     = buzzer_r;
    recov          = 1'b0;
    timed_out      = 1'b0;
    ev_set         = '0;
    ev_clr         = '0;
    ae             = alert_elap_r + 32'd1;
    fe             = fault_elap_r + 32'd1;
    res_nxt        = '0;

    case (cmd.kind)
      CMD_BUTTON: begin
        if (cmd.press) begin
          if (mode_r == MODE_DISARMED) begin
            mode_nxt = MODE_ARMED;
          end else if (mode_r == MODE_ARMED || mode_r == MODE_ALERT) begin
            mode_nxt   = MODE_DISARMED;
            alarm_nxt  = 1'b0;
            door_nxt   = '0;
            motion_nxt = '0;
          end
        end
      end
      CMD_FLAGS, CMD_HB: begin
        seen_nxt[cmd.zone] = 1'b1;
        if (!alive_r[cmd.zone]) begin
          alive_nxt[cmd.zone] = 1'b1;
          fault_nxt[cmd.zone] = 1'b0;
          recov = fault_r[cmd.zone];
        end
        if (cmd.kind == CMD_FLAGS) begin
          door_nxt[cmd.zone]   = cmd.door;
          motion_nxt[cmd.zone] = cmd.motion;
          ev_set = {cmd.motion && !motion_r[cmd.zone], cmd.door && !door_r[cmd.zone]};
          ev_clr = {!cmd.motion && motion_r[cmd.zone], !cmd.door && door_r[cmd.zone]};
        end else begin
          elap_nxt[cmd.zone] = '0;
        end
        // events in order: recovery, then door edge, then motion edge
        if (recov && mode_nxt == MODE_FAULT && fault_nxt == '0) begin
          mode_nxt   = MODE_DISARMED;
          alarm_nxt  = 1'b0;
          door_nxt   = '0;
          motion_nxt = '0;
        end
        for (int e = 0; e < 2; e++) begin
          if (ev_set[e] && mode_nxt == MODE_ARMED) begin
            mode_nxt  = MODE_ALERT;
            alarm_nxt = 1'b1;
          end else if (ev_clr[e] && mode_nxt == MODE_ALERT &&
                       (door_nxt | motion_nxt) == '0) begin
            mode_nxt = MODE_ARMED;
          end
        end
      end
      CMD_TICK: begin
        now_nxt = now_r + 32'd1;
        for (int z = 0; z < ZONES; z++) begin
          elap_nxt[z] = elap_r[z] + 32'd1;
          if (seen_r[z] && !fault_r[z] && elap_nxt[z] > {16'd0, hb_timeout_r}) begin
            alive_nxt[z] = 1'b0;
            fault_nxt[z] = 1'b1;
            timed_out    = 1'b1;
          end
        end
        if (timed_out && alive_nxt == '0) mode_nxt = MODE_FAULT;

        // buzzer
        if (mode_nxt == MODE_ARMED && last_mode_r == MODE_DISARMED) begin
          beep_on_nxt   = 1'b1;
          beep_step_nxt = '0;
          beep_next_nxt = now_nxt;
        end
        last_mode_nxt  = mode_nxt;
        alert_elap_nxt = ae;
        fault_elap_nxt = fe;
        if (mode_nxt == MODE_ALERT && alarm_nxt) begin
          beep_on_nxt = 1'b0;
          if (ae >= {16'd0, alert_tgl_r}) begin
            buzzer_nxt     = !buzzer_r;
            alert_elap_nxt = '0;
          end
        end else if (mode_nxt == MODE_FAULT) begin
          beep_on_nxt = 1'b0;
          if (fe >= {16'd0, fault_tgl_r}) begin
            buzzer_nxt     = !buzzer_r;
            fault_elap_nxt = '0;
          end
        end else if (beep_on_nxt) begin
          if (now_nxt >= beep_next_nxt) begin
            buzzer_nxt    = !beep_step_nxt[0];
            beep_step_nxt = beep_step_nxt + 3'd1;
            beep_next_nxt = now_nxt + {16'd0, arm_beep_r};
            if (beep_step_nxt >= BEEP_STEPS) begin
              beep_on_nxt = 1'b0;
              buzzer_nxt  = 1'b0;
            end
          end
        end else begin
          buzzer_nxt = 1'b0;
        end
      end
      CMD_ACK: begin
        alarm_nxt = 1'b0;
        if (mode_r == MODE_ALERT) mode_nxt = MODE_ARMED;
      end
      CMD_UNKNOWN: res_nxt.unknown = 1'b1;
      default: ;
    endcase

    res_nxt.mode      = mode_nxt;
    res_nxt.alarm     = alarm_nxt;
    res_nxt.buzzer    = buzzer_nxt;
    res_nxt.alive     = alive_nxt;
    res_nxt.triggered = door_nxt | motion_nxt;
    res_nxt.faulted   = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_timeout_r <= HB_TIMEOUT_RST;
      alert_tgl_r  <= ALERT_TGL_RST;
      fault_tgl_r  <= FAULT_TGL_RST;
      arm_beep_r   <= ARM_BEEP_RST;
      mode_r       <= MODE_DISARMED;
      alarm_r      <= 1'b0;
      door_r       <= '0;
      motion_r     <= '0;
      alive_r      <= '1;
      seen_r       <= '0;
      fault_r      <= '0;
      for (int z = 0; z < ZONES; z++) elap_r[z] <= '0;
      now_r        <= '0;
      last_mode_r  <= MODE_DISARMED;
      beep_on_r    <= 1'b0;
      beep_step_r  <= '0;
      beep_next_r  <= '0;
      alert_elap_r <= '0;
      fault_elap_r <= '0;
      buzzer_r     <= 1'b0;
      rwp_r        <= '0;
      rrp_r        <= '0;
      rq_cnt_r     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HB_TIMEOUT: hb_timeout_r <= cfg_data;
          CFG_ALERT_TGL:  alert_tgl_r  <= cfg_data;
          CFG_FAULT_TGL:  fault_tgl_r  <= cfg_data;
          CFG_ARM_BEEP:   arm_beep_r   <= cfg_data;
          default: ;
        endcase
      end
      if (exec) begin
        mode_r       <= mode_nxt;
        alarm_r      <= alarm_nxt;
        door_r       <= door_nxt;
        motion_r     <= motion_nxt;
        alive_r      <= alive_nxt;
        seen_r       <= seen_nxt;
        fault_r      <= fault_nxt;
        elap_r       <= elap_nxt;
        now_r        <= now_nxt;
        last_mode_r  <= last_mode_nxt;
        beep_on_r    <= beep_on_nxt;
        beep_step_r  <= beep_step_nxt;
        beep_next_r  <= beep_next_nxt;
        alert_elap_r <= alert_elap_nxt;
        fault_elap_r <= fault_elap_nxt;
        buzzer_r     <= buzzer_nxt;
        rwp_r <= (rwp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rwp_r + 1'b1;
      end
      if (rpop) begin
        rrp_r <= (rrp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rrp_r + 1'b1;
      end
      if (exec && !rpop) rq_cnt_r <= rq_cnt_r + 1'b1;
      else if (!exec && rpop) rq_cnt_r <= rq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) rq_r[rwp_r] <= res_nxt;
  end

  `ZAC_ASSERT_NOW(a_fault_not_alive, 1'b1, (fault_r & alive_r) == '0, "zone faulted and alive")
  `ZAC_ASSERT_NOW(a_trig_needs_seen, 1'b1, ((door_r | motion_r) & ~seen_r) == '0, "unseen zone triggered")
  `ZAC_ASSERT_NOW(a_alert_has_alarm, mode_r == MODE_ALERT, alarm_r, "alert without alarm flag")
  `ZAC_ASSERT_NOW(a_beep_step_range, 1'b1, beep_step_r <= BEEP_STEPS, "beep step past end")
  `ZAC_ASSERT_NEXT(a_exec_fills_queue, exec && !rpop, rq_cnt_r == $past(rq_cnt_r) + 1'b1, "result not queued")

endmodule

// ===== rtl/zone_alarm_controller_unit.sv =====
// Top level of the zone alarm controller: front decoder/queue, back executor.
// Depends on zac_pkg, zac_front and zac_back.
//
//   channel  handshake             payload
//   in       in_push / in_full     in_operation in_sid_high in_sid_low in_length_code in_first_byte
//   out      out_pop / out_empty   out_mode out_alarm_sounding out_buzzer out_*_mask out_unknown_frame
//   cfg      cfg_valid / cfg_ready cfg_index cfg_data
//
// One item per cycle sustained while out_pop keeps the result queue from filling.
// A pushed item waits in the command queue, is executed by the back end into the result
// queue, and shows on the result ports when it reaches the head of that queue.
// Synchronous reset puts all registers but the queue storage in their reset values; no clearing pass.
// in_full rises when the two-entry command queue is full; the back end holds while the
// two-entry result queue is full and out_pop is low. cfg_ready is always high.
module zone_alarm_controller_unit import zac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_operation,
  input  logic [7:0]           in_sid_high,
  input  logic [7:0]           in_sid_low,
  input  logic [7:0]           in_length_code,
  input  logic [7:0]           in_first_byte,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [1:0]           out_mode,
  output logic                 out_alarm_sounding,
  output logic                 out_buzzer,
  output logic [ZONES-1:0]     out_alive_mask,
  output logic [ZONES-1:0]     out_triggered_mask,
  output logic [ZONES-1:0]     out_faulted_mask,
  output logic                 out_unknown_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  assign cfg_ready = 1'b1;

  zac_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_operation   (in_operation),
    .in_sid_high    (in_sid_high),
    .in_sid_low     (in_sid_low),
    .in_length_code (in_length_code),
    .in_first_byte  (in_first_byte),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take)
  );

  zac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_mode           = res.mode;
  assign out_alarm_sounding = res.alarm;
  assign out_buzzer         = res.buzzer;
  assign out_alive_mask     = res.alive;
  assign out_triggered_mask = res.triggered;
  assign out_faulted_mask   = res.faulted;
  assign out_unknown_frame  = res.unknown;

endmodule

// ===== dv/zone_alarm_controller_unit_tb.sv =====
// Self-checking testbench for zone_alarm_controller_unit: frames, ticks and acks in, status out.
// Holds its own status model in a small tracker class; depends on zac_pkg and the RTL only.
`timescale 1ns / 1ps

module zone_alarm_controller_unit_tb;
  import zac_pkg::*;

  localparam logic [1:0] OP_SPARE        = 2'd3;
  localparam int         CFG_FIRST_UNUSED = 4;
  localparam int         NUM_PHASES      = 8;
  localparam int         ITEMS_PER_PHASE = 228;
  localparam int         DRAIN_CYCLES    = 4;
  localparam int         MAX_PRINTED     = 40;
  localparam int         RUN_LIMIT_NS    = 5_000_000;

  // zone record bit positions
  localparam int ZR_DOOR   = 0;
  localparam int ZR_MOTION = 1;
  localparam int ZR_ALIVE  = 2;
  localparam int ZR_SEEN   = 3;
  localparam int ZR_FAULT  = 4;

  typedef enum logic [1:0] {MODE_DISARMED, MODE_ARMED, MODE_ALERT, MODE_FAULT} sec_mode_t;

  typedef enum int {
    EV_ARM, EV_DISARM, EV_TRIGGERED, EV_CLEARED, EV_TIMEOUT, EV_RECOVERED
  } zone_ev_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] sid_high;
    logic [7:0] sid_low;
    logic [7:0] length_code;
    logic [7:0] first_byte;
  } alarm_item_t;

  localparam int ITEM_W = $bits(alarm_item_t);

  class zone_status_tracker;
    logic [15:0] hb_timeout, alert_tgl, fault_tgl, beep_len;
    sec_mode_t   mode_r, mode_last_tick;
    bit          alarm, beeping, buzz;
    logic [4:0]  zrec [ZONES];
    logic [31:0] hb_time [ZONES];
    logic [31:0] now, beep_due, alert_mark, fault_mark;
    logic [2:0]  beep_idx;
    zone_ev_t    ev_q[$];
    res_t        expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      hb_timeout     = HB_TIMEOUT_RST;
      alert_tgl      = ALERT_TGL_RST;
      fault_tgl      = FAULT_TGL_RST;
      beep_len       = ARM_BEEP_RST;
      mode_r         = MODE_DISARMED;
      mode_last_tick = MODE_DISARMED;
      alarm          = 1'b0;
      beeping        = 1'b0;
      buzz           = 1'b0;
      beep_idx       = '0;
      now            = '0;
      beep_due       = '0;
      alert_mark     = '0;
      fault_mark     = '0;
      mismatches     = 0;
      results_seen   = 0;
      for (int z = 0; z < ZONES; z++) begin
        zrec[z]    = 5'b0;
        zrec[z][ZR_ALIVE] = 1'b1;
        hb_time[z] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_HB_TIMEOUT: hb_timeout = val;
        CFG_ALERT_TGL:  alert_tgl  = val;
        CFG_FAULT_TGL:  fault_tgl  = val;
        CFG_ARM_BEEP:   beep_len   = val;
        default: ;
      endcase
    endfunction

    function bit any_trigger();
      for (int z = 0; z < ZONES; z++)
        if (zrec[z][ZR_DOOR] || zrec[z][ZR_MOTION]) return 1'b1;
      return 1'b0;
    endfunction

    function bit any_fault();
      for (int z = 0; z < ZONES; z++)
        if (zrec[z][ZR_FAULT]) return 1'b1;
      return 1'b0;
    endfunction

    function void go_disarmed();
      mode_r = MODE_DISARMED;
      alarm  = 1'b0;
      for (int z = 0; z < ZONES; z++) begin
        zrec[z][ZR_DOOR]   = 1'b0;
        zrec[z][ZR_MOTION] = 1'b0;
      end
    endfunction

    function void do_event(zone_ev_t ev);
      bit all_down;
      case (ev)
        EV_ARM:    if (mode_r == MODE_DISARMED) mode_r = MODE_ARMED;
        EV_DISARM: go_disarmed();
        EV_TRIGGERED:
          if (mode_r == MODE_ARMED) begin
            mode_r = MODE_ALERT;
            alarm  = 1'b1;
          end
        EV_CLEARED: if (mode_r == MODE_ALERT && !any_trigger()) mode_r = MODE_ARMED;
        EV_TIMEOUT: begin
          all_down = 1'b1;
          for (int z = 0; z < ZONES; z++)
            if (zrec[z][ZR_ALIVE]) all_down = 1'b0;
          if (all_down) mode_r = MODE_FAULT;
        end
        EV_RECOVERED: if (mode_r == MODE_FAULT && !any_fault()) go_disarmed();
        default: ;
      endcase
    endfunction

    function void run_events();
      foreach (ev_q[i]) do_event(ev_q[i]);
      ev_q.delete();
    endfunction

    function void mark_online(int z);
      zrec[z][ZR_SEEN] = 1'b1;
      if (!zrec[z][ZR_ALIVE]) begin
        zrec[z][ZR_ALIVE] = 1'b1;
        if (zrec[z][ZR_FAULT]) begin
          zrec[z][ZR_FAULT] = 1'b0;
          ev_q.push_back(EV_RECOVERED);
        end
      end
    endfunction

    function void flag_edge(int z, int pos, bit now_set);
      bit was;
      was = zrec[z][pos];
      zrec[z][pos] = now_set;
      if (now_set && !was) ev_q.push_back(EV_TRIGGERED);
      else if (!now_set && was) ev_q.push_back(EV_CLEARED);
    endfunction

    // returns 1 when the frame id was recognized
    function bit decode_frame(logic [10:0] id, logic [3:0] cnt, logic [7:0] b0);
      if (id == 11'(ID_BUTTON) && cnt != 4'd0) begin
        if (b0 == BTN_PRESS) begin
          if (mode_r == MODE_DISARMED) do_event(EV_ARM);
          else if (mode_r != MODE_FAULT) do_event(EV_DISARM);
        end
        return 1'b1;
      end
      for (int z = 0; z < ZONES; z++) begin
        if (id == 11'(ID_FLAGS_BASE + z * ID_ZONE_STRIDE) && cnt != 4'd0) begin
          mark_online(z);
          flag_edge(z, ZR_DOOR, b0[0]);
          flag_edge(z, ZR_MOTION, b0[1]);
          run_events();
          return 1'b1;
        end
      end
      // heartbeats are accepted with any payload length
      for (int z = 0; z < ZONES; z++) begin
        if (id == 11'(ID_HB_BASE + z * ID_ZONE_STRIDE)) begin
          mark_online(z);
          hb_time[z] = now;
          run_events();
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void watchdog();
      logic [31:0] age;
      for (int z = 0; z < ZONES; z++) begin
        age = now - hb_time[z];
        if (zrec[z][ZR_SEEN] && age > 32'(hb_timeout) && !zrec[z][ZR_FAULT]) begin
          zrec[z][ZR_ALIVE] = 1'b0;
          zrec[z][ZR_FAULT] = 1'b1;
          ev_q.push_back(EV_TIMEOUT);
        end
      end
      run_events();
    endfunction

    function void buzzer_step();
      logic [31:0] since;
      if (mode_r == MODE_ARMED && mode_last_tick == MODE_DISARMED) begin
        beeping  = 1'b1;
        beep_idx = '0;
        beep_due = now;
      end
      mode_last_tick = mode_r;
      if (mode_r == MODE_ALERT && alarm) begin
        beeping = 1'b0;
        since   = now - alert_mark;
        if (since >= 32'(alert_tgl)) begin
          buzz       = ~buzz;
          alert_mark = now;
        end
      end else if (mode_r == MODE_FAULT) begin
        beeping = 1'b0;
        since   = now - fault_mark;
        if (since >= 32'(fault_tgl)) begin
          buzz       = ~buzz;
          fault_mark = now;
        end
      end else if (beeping) begin
        // plain unsigned deadline compare, no wrap handling
        if (now >= beep_due) begin
          buzz     = ~beep_idx[0];
          beep_idx = beep_idx + 3'd1;
          beep_due = now + 32'(beep_len);
          if (beep_idx >= BEEP_STEPS) begin
            beeping = 1'b0;
            buzz    = 1'b0;
          end
        end
      end else begin
        buzz = 1'b0;
      end
    endfunction

    function void log_accepted_item(alarm_item_t it);
      res_t r;
      bit   unk;
      unk = 1'b0;
      ev_q.delete();
      case (it.op)
        OP_FRAME: unk = !decode_frame({it.sid_high, it.sid_low[7:5]}, it.length_code[3:0],
                                      it.first_byte);
        OP_TICK: begin
          now = now + 32'd1;
          watchdog();
          buzzer_step();
        end
        OP_ACK: begin
          alarm = 1'b0;
          if (mode_r == MODE_ALERT) mode_r = MODE_ARMED;
        end
        default: ;
      endcase
      r.mode   = mode_r;
      r.alarm  = alarm;
      r.buzzer = buzz;
      for (int z = 0; z < ZONES; z++) begin
        r.alive[z]     = zrec[z][ZR_ALIVE];
        r.triggered[z] = zrec[z][ZR_DOOR] | zrec[z][ZR_MOTION];
        r.faulted[z]   = zrec[z][ZR_FAULT];
      end
      r.unknown = unk;
      expected_q.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] status mismatch: %s", $time, what);
    endtask

    task check_status(res_t got);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with none pending: %h", results_seen, got));
        return;
      end
      want = expected_q.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("result %0d mode %0d want %0d", results_seen, got.mode, want.mode));
      if (got.alarm !== want.alarm)
        report($sformatf("result %0d alarm %b want %b", results_seen, got.alarm, want.alarm));
      if (got.buzzer !== want.buzzer)
        report($sformatf("result %0d buzzer %b want %b", results_seen, got.buzzer,
                         want.buzzer));
      if (got.alive !== want.alive)
        report($sformatf("result %0d alive %b want %b", results_seen, got.alive, want.alive));
      if (got.triggered !== want.triggered)
        report($sformatf("result %0d triggered %b want %b", results_seen, got.triggered,
                         want.triggered));
      if (got.faulted !== want.faulted)
        report($sformatf("result %0d faulted %b want %b", results_seen, got.faulted,
                         want.faulted));
      if (got.unknown !== want.unknown)
        report($sformatf("result %0d unknown %b want %b", results_seen, got.unknown,
                         want.unknown));
    endtask
  endclass

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_push        = 1'b0;
  logic                 in_full;
  logic [1:0]           in_operation   = '0;
  logic [7:0]           in_sid_high    = '0;
  logic [7:0]           in_sid_low     = '0;
  logic [7:0]           in_length_code = '0;
  logic [7:0]           in_first_byte  = '0;
  logic                 out_empty;
  logic                 out_pop        = 1'b0;
  logic [1:0]           out_mode;
  logic                 out_alarm_sounding;
  logic                 out_buzzer;
  logic [ZONES-1:0]     out_alive_mask;
  logic [ZONES-1:0]     out_triggered_mask;
  logic [ZONES-1:0]     out_faulted_mask;
  logic                 out_unknown_frame;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [15:0]          cfg_data       = '0;

  zone_status_tracker tracker = new();

  bit          push_burst = 1'b0;
  bit          pop_free   = 1'b0;
  int unsigned pop_hold   = 0;

  zone_alarm_controller_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_operation       (in_operation),
    .in_sid_high        (in_sid_high),
    .in_sid_low         (in_sid_low),
    .in_length_code     (in_length_code),
    .in_first_byte      (in_first_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_mode           (out_mode),
    .out_alarm_sounding (out_alarm_sounding),
    .out_buzzer         (out_buzzer),
    .out_alive_mask     (out_alive_mask),
    .out_triggered_mask (out_triggered_mask),
    .out_faulted_mask   (out_faulted_mask),
    .out_unknown_frame  (out_unknown_frame),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: sample at the edge, then decide pop for the next one
  always @(posedge clk) begin
    res_t got;
    got.mode      = out_mode;
    got.alarm     = out_alarm_sounding;
    got.buzzer    = out_buzzer;
    got.alive     = out_alive_mask;
    got.triggered = out_triggered_mask;
    got.faulted   = out_faulted_mask;
    got.unknown   = out_unknown_frame;
    if (rst_n && out_pop && !out_empty) tracker.check_status(got);
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if (!pop_free && $urandom_range(0, 99) < 25) pop_hold = pick_gap();
    end
  end

  task automatic send_item(input alarm_item_t it, input bit last);
    int unsigned gap;
    in_push        <= 1'b1;
    in_operation   <= it.op;
    in_sid_high    <= it.sid_high;
    in_sid_low     <= it.sid_low;
    in_length_code <= it.length_code;
    in_first_byte  <= it.first_byte;
    do @(posedge clk); while (in_full);
    tracker.log_accepted_item(it);
    gap = (push_burst || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (last || gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    do @(posedge clk); while (tracker.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // block must be idle here; one stray out-of-range index goes in first
  task automatic program_regs(input logic [15:0] hb, alert, fault, beep);
    logic [CFG_IDX_W-1:0] idx_q[$];
    logic [15:0]          val_q[$];
    idx_q = '{CFG_HB_TIMEOUT, CFG_ALERT_TGL, CFG_FAULT_TGL, CFG_ARM_BEEP};
    val_q = '{hb, alert, fault, beep};
    idx_q.push_front(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)));
    val_q.push_front(16'($urandom));
    foreach (idx_q[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_q[i];
      cfg_data  <= val_q[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.set_reg(idx_q[i], val_q[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic alarm_item_t frame_item(logic [10:0] id, logic [3:0] cnt,
                                             logic [7:0] b0);
    alarm_item_t it;
    it.op          = OP_FRAME;
    it.sid_high    = id[10:3];
    it.sid_low     = {id[2:0], 5'b0};
    it.length_code = {4'h0, cnt};
    it.first_byte  = b0;
    return it;
  endfunction

  function automatic alarm_item_t ctl_item(logic [1:0] op);
    alarm_item_t it;
    it    = '0;
    it.op = op;
    return it;
  endfunction

  function automatic logic [10:0] flags_id(int z);
    return 11'(ID_FLAGS_BASE + z * ID_ZONE_STRIDE);
  endfunction

  function automatic logic [10:0] hb_id(int z);
    return 11'(ID_HB_BASE + z * ID_ZONE_STRIDE);
  endfunction

  // mostly well-formed traffic with random content, some noise ids
  function automatic alarm_item_t rand_item(int unsigned hb_pct);
    alarm_item_t it;
    int unsigned r;
    logic [10:0] id;
    it = alarm_item_t'(ITEM_W'({$urandom, $urandom}));
    r  = $urandom_range(0, 99);
    if (r < 45) begin
      it.op = OP_TICK;
    end else if (r < 51) begin
      it.op = OP_ACK;
    end else if (r < 53) begin
      it.op = OP_SPARE;
    end else begin
      it.op = OP_FRAME;
      r     = $urandom_range(0, 99);
      if (r < 8) id = 11'($urandom);
      else if (r < 22) id = 11'(ID_BUTTON);
      else if (r < 22 + hb_pct) id = hb_id($urandom_range(0, ZONES - 1));
      else id = flags_id($urandom_range(0, ZONES - 1));
      it.sid_high         = id[10:3];
      it.sid_low[7:5]     = id[2:0];
      it.length_code[3:0] = ($urandom_range(0, 99) < 8) ? 4'h0 : 4'($urandom_range(1, 15));
      if (id == 11'(ID_BUTTON) && $urandom_range(0, 3) != 0) it.first_byte = BTN_PRESS;
    end
    return it;
  endfunction

  task automatic run_directed();
    alarm_item_t seq[$];
    seq.push_back(alarm_item_t'{OP_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    seq.push_back(alarm_item_t'{OP_FRAME, 8'h00, 8'h00, 8'h00, 8'h00});
    seq.push_back(alarm_item_t'{OP_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    seq.push_back(frame_item(11'(ID_BUTTON), 4'd0, BTN_PRESS));   // empty payload
    seq.push_back(frame_item(11'(ID_BUTTON), 4'd1, 8'h00));       // released
    seq.push_back(frame_item(11'(ID_BUTTON), 4'd15, BTN_PRESS));
    seq.push_back(ctl_item(OP_TICK));                             // arm beeps start
    seq.push_back(frame_item(flags_id(0), 4'd0, 8'h01));
    seq.push_back(frame_item(flags_id(0), 4'd1, 8'h01));
    seq.push_back(ctl_item(OP_TICK));
    seq.push_back(ctl_item(OP_ACK));
    seq.push_back(frame_item(flags_id(1), 4'd2, 8'h02));
    seq.push_back(frame_item(flags_id(0), 4'd1, 8'h00));
    seq.push_back(frame_item(flags_id(1), 4'd1, 8'hFC));
    seq.push_back(ctl_item(OP_TICK));
    seq.push_back(frame_item(11'(ID_BUTTON), 4'd1, BTN_PRESS));   // disarm
    seq.push_back(frame_item(hb_id(0), 4'd0, 8'h00));
    seq.push_back(frame_item(hb_id(1), 4'd8, 8'hFF));
    seq.push_back(frame_item(flags_id(0), 4'd1, 8'h03));
    seq.push_back(frame_item(11'(ID_BUTTON), 4'd1, BTN_PRESS));
    seq.push_back(ctl_item(OP_TICK));
    seq.push_back(ctl_item(OP_ACK));
    seq.push_back(ctl_item(OP_SPARE));
    foreach (seq[i]) send_item(seq[i], i == seq.size() - 1);
  endtask

  initial begin
    int unsigned hb_pct;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    wait_for_drain();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_regs(16'd1, 16'd1, 16'd1, 16'd1);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        6: program_regs(HB_TIMEOUT_RST, ALERT_TGL_RST, FAULT_TGL_RST, ARM_BEEP_RST);
        default: program_regs(16'($urandom_range(2, 30)), 16'($urandom_range(1, 6)),
                              16'($urandom_range(1, 10)), 16'($urandom_range(1, 5)));
      endcase
      hb_pct     = $urandom_range(2, 35);
      push_burst = (ph % 4 == 1) || ($urandom_range(0, 3) == 0);
      pop_free   = (ph % 4 == 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(rand_item(hb_pct), n == ITEMS_PER_PHASE - 1);
      wait_for_drain();
    end
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
